FILE: hw/rtl/mahrc_pkg.sv
// Package for the moving-average hysteresis rep counter.
// Holds configuration register codes, register widths and reset values.
// No dependencies.
package mahrc_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 21;
   localparam int THRESH_W   = 21;
   localparam int REPS_W     = 8;
   localparam int WARMUP_W   = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REP_TARGET      = 3'd0,
      CSR_WARMUP_SAMPLES  = 3'd1,
      CSR_ACTIVE_WHEN_LOW = 3'd2,
      CSR_ENTER_THRESHOLD = 3'd3,
      CSR_EXIT_THRESHOLD  = 3'd4
   } csr_index_type;

   localparam logic [REPS_W-1:0]          REP_TARGET_RST      = 8'd5;
   localparam logic [WARMUP_W-1:0]        WARMUP_SAMPLES_RST  = 12'd401;
   localparam logic                       ACTIVE_WHEN_LOW_RST = 1'b1;
   localparam logic signed [THRESH_W-1:0] ENTER_THRESHOLD_RST = 21'sd202980;
   localparam logic signed [THRESH_W-1:0] EXIT_THRESHOLD_RST  = 21'sd332540;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_START  = 1'b1;

endpackage

FILE: hw/rtl/mahrc_req_if.sv
// Request channel for the rep counter: valid/ready plus command and sample.
// Depends on nothing; sample width follows SAMPLE_BITS.
interface mahrc_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output cmd, output sample, input ready);
   modport sink   (input valid, input cmd, input sample, output ready);
endinterface

FILE: hw/rtl/mahrc_rsp_if.sv
// Response channel for the rep counter: valid/ready plus result fields.
// Depends on mahrc_pkg for the count width.
interface mahrc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           active_led;
   logic                           rep_counted;
   logic [mahrc_pkg::REPS_W-1:0]   reps_left;
   logic                           done_res;

   modport source (output valid, output active_led, output rep_counted,
                   output reps_left, output done_res, input ready);
   modport sink   (input valid, input active_led, input rep_counted,
                   input reps_left, input done_res, output ready);
endinterface

FILE: hw/rtl/moving_average_hysteresis_rep_counter.sv
// Each accepted request transaction is registered into the response register.
// Throughput: one transaction per cycle; window sum, shift line and both
// threshold compares update in the accept cycle, the response register
// decouples the sides (ready = response register empty or being drained).
// Reset (synchronous, active high) clears window, sum, hysteresis state and
// the rep count (block reports done until the first start); loads CSR defaults.
module moving_average_hysteresis_rep_counter #(
   parameter int WINDOW      = 20,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   mahrc_req_if.sink                              req_chan,
   mahrc_rsp_if.source                            rsp_chan,
   input  logic                                   csr_we,
   input  logic [mahrc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mahrc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);
   localparam int CMP_W = (SUM_W > mahrc_pkg::THRESH_W) ? SUM_W + 1
                                                        : mahrc_pkg::THRESH_W + 1;

   // configuration
   logic [mahrc_pkg::REPS_W-1:0]             rep_target_ff;
   logic [mahrc_pkg::WARMUP_W-1:0]           warmup_samples_ff;
   logic                                     active_when_low_ff;
   logic signed [mahrc_pkg::THRESH_W-1:0]    enter_threshold_ff;
   logic signed [mahrc_pkg::THRESH_W-1:0]    exit_threshold_ff;

   // set state
   logic signed [SAMPLE_BITS-1:0] window_ff [WINDOW];
   logic signed [SAMPLE_BITS-1:0] window_in [WINDOW];
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic [mahrc_pkg::WARMUP_W-1:0] warmup_seen_ff, warmup_seen_in;
   logic                          in_active_ff, in_active_in;
   logic                          rep_pending_ff, rep_pending_in;
   logic                          led_ff, led_in;
   logic [mahrc_pkg::REPS_W-1:0]  reps_ff, reps_in;
   logic                          counted_in;

   // response register
   logic                          rsp_valid_ff;
   logic                          rsp_led_ff, rsp_counted_ff, rsp_done_ff;
   logic [mahrc_pkg::REPS_W-1:0]  rsp_reps_ff;

   logic                          req_fire;
   logic signed [CMP_W-1:0]       sum_ext, enter_ext, exit_ext;
   logic                          enter_hit, exit_hit;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.active_led  = rsp_led_ff;
   assign rsp_chan.rep_counted = rsp_counted_ff;
   assign rsp_chan.reps_left   = rsp_reps_ff;
   assign rsp_chan.done_res    = rsp_done_ff;

   always_comb begin
      window_in[0] = req_chan.sample;
      for (int i = 1; i < WINDOW; i++) begin
         window_in[i] = window_ff[i-1];
      end
      // drop the oldest sample, add the new one
      sum_in    = sum_ff - SUM_W'(window_ff[WINDOW-1]) + SUM_W'(req_chan.sample);
      sum_ext   = CMP_W'(sum_in);
      enter_ext = CMP_W'(enter_threshold_ff);
      exit_ext  = CMP_W'(exit_threshold_ff);
      enter_hit = active_when_low_ff ? (sum_ext < enter_ext) : (sum_ext > enter_ext);
      exit_hit  = active_when_low_ff ? (sum_ext > exit_ext) : (sum_ext < exit_ext);

      warmup_seen_in = warmup_seen_ff;
      in_active_in   = in_active_ff;
      rep_pending_in = rep_pending_ff;
      led_in         = led_ff;
      reps_in        = reps_ff;
      counted_in     = 1'b0;

      if (warmup_seen_ff < warmup_samples_ff) begin
         warmup_seen_in = warmup_seen_ff + 1'b1;
      end else if (!in_active_ff) begin
         led_in = 1'b0;
         if (rep_pending_ff) begin
            rep_pending_in = 1'b0;
            reps_in        = reps_ff - 1'b1;
            counted_in     = 1'b1;
         end
         if (enter_hit) begin
            in_active_in = 1'b1;
         end
      end else begin
         led_in         = 1'b1;
         rep_pending_in = 1'b1;
         if (exit_hit) begin
            in_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rep_target_ff      <= mahrc_pkg::REP_TARGET_RST;
         warmup_samples_ff  <= mahrc_pkg::WARMUP_SAMPLES_RST;
         active_when_low_ff <= mahrc_pkg::ACTIVE_WHEN_LOW_RST;
         enter_threshold_ff <= mahrc_pkg::ENTER_THRESHOLD_RST;
         exit_threshold_ff  <= mahrc_pkg::EXIT_THRESHOLD_RST;
      end else if (csr_we) begin
         case (mahrc_pkg::csr_index_type'(csr_index))
            mahrc_pkg::CSR_REP_TARGET:
               rep_target_ff <= csr_wdata[mahrc_pkg::REPS_W-1:0];
            mahrc_pkg::CSR_WARMUP_SAMPLES:
               warmup_samples_ff <= csr_wdata[mahrc_pkg::WARMUP_W-1:0];
            mahrc_pkg::CSR_ACTIVE_WHEN_LOW:
               active_when_low_ff <= csr_wdata[0];
            mahrc_pkg::CSR_ENTER_THRESHOLD:
               enter_threshold_ff <= csr_wdata[mahrc_pkg::THRESH_W-1:0];
            mahrc_pkg::CSR_EXIT_THRESHOLD:
               exit_threshold_ff <= csr_wdata[mahrc_pkg::THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            window_ff[i] <= '0;
         end
         sum_ff         <= '0;
         warmup_seen_ff <= '0;
         in_active_ff   <= 1'b0;
         rep_pending_ff <= 1'b0;
         led_ff         <= 1'b0;
         reps_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire) begin
            if (req_chan.cmd == mahrc_pkg::CMD_START) begin
               for (int i = 0; i < WINDOW; i++) begin
                  window_ff[i] <= '0;
               end
               sum_ff         <= '0;
               warmup_seen_ff <= '0;
               in_active_ff   <= 1'b0;
               rep_pending_ff <= 1'b0;
               led_ff         <= 1'b0;
               reps_ff        <= rep_target_ff;
            end else if (reps_ff != '0) begin
               window_ff      <= window_in;
               sum_ff         <= sum_in;
               warmup_seen_ff <= warmup_seen_in;
               in_active_ff   <= in_active_in;
               rep_pending_ff <= rep_pending_in;
               led_ff         <= led_in;
               reps_ff        <= reps_in;
            end
         end
      end
   end

   // response payload: hold while stalled
   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (req_chan.cmd == mahrc_pkg::CMD_START) begin
            rsp_led_ff     <= 1'b0;
            rsp_counted_ff <= 1'b0;
            rsp_reps_ff    <= rep_target_ff;
            rsp_done_ff    <= (rep_target_ff == '0);
         end else if (reps_ff != '0) begin
            rsp_led_ff     <= led_in;
            rsp_counted_ff <= counted_in;
            rsp_reps_ff    <= reps_in;
            rsp_done_ff    <= (reps_in == '0);
         end else begin
            rsp_led_ff     <= led_ff;
            rsp_counted_ff <= 1'b0;
            rsp_reps_ff    <= reps_ff;
            rsp_done_ff    <= 1'b1;
         end
      end
   end

   a_start_loads_target : assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.cmd == mahrc_pkg::CMD_START
      |=> rsp_chan.valid && rsp_chan.reps_left == $past(rep_target_ff)
          && !rsp_chan.active_led)
      else $error("start did not load the rep target");

   a_count_in_rest : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.rep_counted |-> !rsp_chan.active_led && !rsp_chan.done_res
         || rsp_chan.reps_left == '0)
      else $error("rep counted outside rest");

   a_done_holds : assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.cmd == mahrc_pkg::CMD_SAMPLE && reps_ff == '0
      |=> reps_ff == '0 && $stable(sum_ff) && $stable(in_active_ff))
      else $error("sample changed state while done");

   a_count_steps_by_one : assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.cmd == mahrc_pkg::CMD_SAMPLE && counted_in && reps_ff != '0
      |=> reps_ff == $past(reps_ff) - 1'b1 && rsp_chan.rep_counted)
      else $error("rep count did not step by one");

endmodule
